// File: src/rcms_pkg.sv
// ----------------------------------------------------------------------------
// rcms_pkg
// Shared types, constants and drive tables of the motor command sequencer.
// ----------------------------------------------------------------------------
package rcms_pkg;

  localparam int DEMO_STEPS  = 5;
  localparam int STEP_SLOTS  = 5;
  localparam int MS_W        = 16;
  localparam int SPEED_W     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam logic [SPEED_W:0] SPEED_MAX = 9'd150;

  // Input item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_TIMEOUT = 3'd0,
    REG_STEP0        = 3'd1,
    REG_STEP1        = 3'd2,
    REG_STEP2        = 3'd3,
    REG_STEP3        = 3'd4,
    REG_STEP4        = 3'd5
  } reg_idx_t;

  localparam logic [MS_W-1:0] IDLE_TIMEOUT_RST = 16'd3000;
  localparam logic [MS_W-1:0] STEP_FWD_RST     = 16'd1000;
  localparam logic [MS_W-1:0] STEP_TURN_RST    = 16'd800;

  // Result causes
  typedef enum logic [1:0] {
    CAUSE_KEY  = 2'd0,
    CAUSE_STEP = 2'd1,
    CAUSE_DONE = 2'd2,
    CAUSE_IDLE = 2'd3
  } cause_t;

  // Command characters
  localparam logic [7:0] CH_STOP = "0";
  localparam logic [7:0] CH_W_UP = "W";
  localparam logic [7:0] CH_W_LO = "w";
  localparam logic [7:0] CH_I_UP = "I";
  localparam logic [7:0] CH_I_LO = "i";
  localparam logic [7:0] CH_A_UP = "A";
  localparam logic [7:0] CH_A_LO = "a";
  localparam logic [7:0] CH_D_UP = "D";
  localparam logic [7:0] CH_D_LO = "d";
  localparam logic [7:0] CH_S_UP = "S";
  localparam logic [7:0] CH_S_LO = "s";
  localparam logic [7:0] CH_K_UP = "K";
  localparam logic [7:0] CH_K_LO = "k";
  localparam logic [7:0] CH_E_UP = "E";
  localparam logic [7:0] CH_E_LO = "e";

  typedef logic signed [SPEED_W:0] speed_s_t;

  // Demo step speeds, signed
  localparam speed_s_t STEP_LEFT  [STEP_SLOTS] = '{9'sd100, -9'sd50, 9'sd100, 9'sd150, -9'sd150};
  localparam speed_s_t STEP_RIGHT [STEP_SLOTS] = '{9'sd100, 9'sd150, 9'sd100, -9'sd50, -9'sd150};

  typedef struct packed {
    logic [MS_W-1:0]                 idle_timeout;
    logic [STEP_SLOTS-1:0][MS_W-1:0] step_ms;
  } cfg_t;

  typedef struct packed {
    logic               left_reverse;
    logic [SPEED_W-1:0] left_speed;
    logic               right_reverse;
    logic [SPEED_W-1:0] right_speed;
    cause_t             cause;
  } drive_t;

  typedef enum logic [1:0] {
    KEY_NONE  = 2'd0,
    KEY_DRIVE = 2'd1,
    KEY_DEMO  = 2'd2
  } key_kind_t;

  typedef struct packed {
    key_kind_t kind;
    speed_s_t  left;
    speed_s_t  right;
  } key_t;

  // Signed speeds to magnitude plus reverse flag, saturated
  function automatic drive_t make_drive(speed_s_t a, speed_s_t b, cause_t c);
    logic [SPEED_W:0] ma;
    logic [SPEED_W:0] mb;
    drive_t d;
    ma = a[SPEED_W] ? 9'(-a) : 9'(a);
    mb = b[SPEED_W] ? 9'(-b) : 9'(b);
    if (ma > SPEED_MAX) ma = SPEED_MAX;
    if (mb > SPEED_MAX) mb = SPEED_MAX;
    d.left_reverse  = a[SPEED_W];
    d.left_speed    = ma[SPEED_W-1:0];
    d.right_reverse = b[SPEED_W];
    d.right_speed   = mb[SPEED_W-1:0];
    d.cause         = c;
    return d;
  endfunction

  // Step number to table slot: index modulo five over three bits
  function automatic logic [2:0] step_slot(logic [2:0] idx);
    return (idx >= 3'(STEP_SLOTS)) ? 3'(idx - 3'(STEP_SLOTS)) : idx;
  endfunction

  function automatic key_t key_decode(logic [7:0] ch);
    key_t k;
    k.kind  = KEY_DRIVE;
    k.left  = '0;
    k.right = '0;
    unique case (ch) inside
      CH_STOP:                          begin k.left = 9'sd0;    k.right = 9'sd0;    end
      CH_W_UP, CH_W_LO, CH_I_UP, CH_I_LO: begin k.left = 9'sd100;  k.right = 9'sd100;  end
      CH_A_UP, CH_A_LO:                 begin k.left = -9'sd50;  k.right = 9'sd150;  end
      CH_D_UP, CH_D_LO:                 begin k.left = 9'sd150;  k.right = -9'sd50;  end
      CH_S_UP, CH_S_LO:                 begin k.left = -9'sd150; k.right = -9'sd150; end
      CH_K_UP, CH_K_LO:                 begin k.left = 9'sd150;  k.right = 9'sd150;  end
      CH_E_UP, CH_E_LO:                 k.kind = KEY_DEMO;
      default:                          k.kind = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

// File: src/remote_command_motor_sequencer_top.sv
// ----------------------------------------------------------------------------
// remote_command_motor_sequencer_top
// Turns command bytes and millisecond ticks into two-wheel drive commands.
// ----------------------------------------------------------------------------
// Pipeline: two register stages; the input register holds an accepted item,
//   and the core step that takes it loads the result register and raises out_valid.
// Throughput: one item per cycle while out_ready stays high, as the core
//   updates its state once per item; while a result waits the input
//   register takes one more item and then holds in_ready low.
// Reset: synchronous, active low; clears sequencer and idle timer state and
//   loads the register defaults (timeout 3000, step lengths 1000/800).
module remote_command_motor_sequencer_top
  import rcms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // command bytes and ticks
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [7:0]           in_rx_byte,
  // drive commands
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_left_reverse,
  output logic [SPEED_W-1:0]   out_left_speed,
  output logic                 out_right_reverse,
  output logic [SPEED_W-1:0]   out_right_speed,
  output logic [1:0]           out_cause,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_data
);

  cfg_t   cfg;
  logic   s1_valid_r;
  logic   s1_op_r;
  logic [7:0] s1_byte_r;
  logic   s2_fire;
  logic   in_fire;
  logic   res_valid;
  drive_t res;
  logic   out_valid_r;
  drive_t out_drive_r;

  // The register file never stalls the configuration port.
  assign cfg_ready = 1'b1;

  rcms_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The core takes the held item whenever the result register is free or
  // being emptied this cycle; items that give no result pass straight on.
  assign s2_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_fire;
  assign in_fire  = in_valid && in_ready;

  // Input register: hold the item until the core has taken it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s2_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_op;
      s1_byte_r <= in_rx_byte;
    end
  end

  // Core: advance the demo and idle timer once per item taken.
  rcms_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s2_fire),
    .op        (s1_op_r),
    .rx_byte   (s1_byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: load on a core step, drop once the item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && res_valid) begin
      out_drive_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_reverse  = out_drive_r.left_reverse;
  assign out_left_speed    = out_drive_r.left_speed;
  assign out_right_reverse = out_drive_r.right_reverse;
  assign out_right_speed   = out_drive_r.right_speed;
  assign out_cause         = out_drive_r.cause;

endmodule

// File: src/rcms_cfg_regs.sv
// ----------------------------------------------------------------------------
// rcms_cfg_regs
// Timeout and demo step length registers behind the configuration port.
// ----------------------------------------------------------------------------
module rcms_cfg_regs
  import rcms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [MS_W-1:0]      wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_IDLE_TIMEOUT: cfg_nxt.idle_timeout = wr_data;
        REG_STEP0:        cfg_nxt.step_ms[0]   = wr_data;
        REG_STEP1:        cfg_nxt.step_ms[1]   = wr_data;
        REG_STEP2:        cfg_nxt.step_ms[2]   = wr_data;
        REG_STEP3:        cfg_nxt.step_ms[3]   = wr_data;
        REG_STEP4:        cfg_nxt.step_ms[4]   = wr_data;
        default:          cfg_nxt = cfg_r;  // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_timeout <= IDLE_TIMEOUT_RST;
      cfg_r.step_ms[0]   <= STEP_FWD_RST;
      cfg_r.step_ms[1]   <= STEP_TURN_RST;
      cfg_r.step_ms[2]   <= STEP_FWD_RST;
      cfg_r.step_ms[3]   <= STEP_TURN_RST;
      cfg_r.step_ms[4]   <= STEP_FWD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/rcms_core.sv
// ----------------------------------------------------------------------------
// rcms_core
// Demo sequencer and idle timer state with the per-item drive decision.
// ----------------------------------------------------------------------------
module rcms_core
  import rcms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic       op,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output drive_t     res
);

  logic            demo_running_r, demo_running_nxt;
  logic [2:0]      step_index_r,   step_index_nxt;
  logic [MS_W-1:0] step_elapsed_r, step_elapsed_nxt;
  logic [MS_W-1:0] idle_elapsed_r, idle_elapsed_nxt;
  logic            idle_armed_r,   idle_armed_nxt;

  key_t          key;
  logic [MS_W:0] step_next;
  logic [MS_W:0] idle_next;
  logic [2:0]    cur_slot;
  logic [3:0]    next_index;
  logic [2:0]    next_slot;

  assign key        = key_decode(rx_byte);
  assign step_next  = {1'b0, step_elapsed_r} + 17'd1;
  assign idle_next  = {1'b0, idle_elapsed_r} + 17'd1;
  assign cur_slot   = step_slot(step_index_r);
  assign next_index = {1'b0, step_index_r} + 4'd1;
  assign next_slot  = step_slot(next_index[2:0]);

  always_comb begin
    demo_running_nxt = demo_running_r;
    step_index_nxt   = step_index_r;
    step_elapsed_nxt = step_elapsed_r;
    idle_elapsed_nxt = idle_elapsed_r;
    idle_armed_nxt   = idle_armed_r;
    res_valid        = 1'b0;
    res              = make_drive('0, '0, CAUSE_KEY);

    if (op == OP_BYTE) begin
      // every byte restarts the idle timer
      idle_elapsed_nxt = '0;
      idle_armed_nxt   = 1'b1;
      unique case (key.kind)
        KEY_DRIVE: begin
          demo_running_nxt = 1'b0;
          res_valid        = 1'b1;
          res              = make_drive(key.left, key.right, CAUSE_KEY);
        end
        KEY_DEMO: begin
          demo_running_nxt = 1'b1;
          step_index_nxt   = '0;
          step_elapsed_nxt = '0;
          res_valid        = 1'b1;
          res              = make_drive(STEP_LEFT[0], STEP_RIGHT[0], CAUSE_STEP);
        end
        default: ;
      endcase
    end else if (demo_running_r) begin
      if (step_next >= {1'b0, cfg.step_ms[cur_slot]}) begin
        res_valid = 1'b1;
        if (next_index >= 4'(DEMO_STEPS)) begin
          demo_running_nxt = 1'b0;
          idle_armed_nxt   = 1'b0;
          res              = make_drive('0, '0, CAUSE_DONE);
        end else begin
          step_index_nxt   = next_index[2:0];
          step_elapsed_nxt = '0;
          res = make_drive(STEP_LEFT[next_slot], STEP_RIGHT[next_slot], CAUSE_STEP);
        end
      end else begin
        step_elapsed_nxt = step_next[MS_W-1:0];
      end
    end else if (idle_armed_r) begin
      if (idle_next > {1'b0, cfg.idle_timeout}) begin
        idle_armed_nxt = 1'b0;
        res_valid      = 1'b1;
        res            = make_drive('0, '0, CAUSE_IDLE);
      end else begin
        idle_elapsed_nxt = idle_next[MS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      demo_running_r <= 1'b0;
      step_index_r   <= '0;
      step_elapsed_r <= '0;
      idle_elapsed_r <= '0;
      idle_armed_r   <= 1'b0;
    end else if (fire) begin
      demo_running_r <= demo_running_nxt;
      step_index_r   <= step_index_nxt;
      step_elapsed_r <= step_elapsed_nxt;
      idle_elapsed_r <= idle_elapsed_nxt;
      idle_armed_r   <= idle_armed_nxt;
    end
  end

endmodule

// File: src/rcms_checker.sv
// ----------------------------------------------------------------------------
// rcms_checker
// Port-level checks on the drive command channel of the sequencer.
// ----------------------------------------------------------------------------
module rcms_checker
  import rcms_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_left_reverse,
  input logic [SPEED_W-1:0]   out_left_speed,
  input logic                 out_right_reverse,
  input logic [SPEED_W-1:0]   out_right_speed,
  input logic [1:0]           out_cause
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_speed)
      && $stable(out_right_speed) && $stable(out_cause))
    else $error("stalled drive command changed");

  // Speeds saturate at the motor limit.
  a_speed_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_speed <= SPEED_MAX[SPEED_W-1:0]
      && out_right_speed <= SPEED_MAX[SPEED_W-1:0])
    else $error("speed above limit");

  // Demo end and idle timeout always command a full stop.
  a_auto_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_cause == CAUSE_DONE || out_cause == CAUSE_IDLE)
      |-> out_left_speed == '0 && out_right_speed == '0
        && !out_left_reverse && !out_right_reverse)
    else $error("automatic stop carries motion");

  // Every demo step drives at least one wheel.
  a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cause == CAUSE_STEP
      |-> out_left_speed != '0 || out_right_speed != '0)
    else $error("demo step without motion");

endmodule

bind remote_command_motor_sequencer_top rcms_checker u_rcms_checker (.*);

// File: sim/rcms_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rcms_tb_pkg
// Scoreboard for the motor command sequencer: mirrors the sequencer state and
// the registers, predicts the drive command of every accepted item and checks
// the drive commands that come out against those predictions, in order.
// ----------------------------------------------------------------------------
package rcms_tb_pkg;
  import rcms_pkg::*;

  class drive_scoreboard;
    // mirrored registers
    logic [MS_W-1:0] idle_limit;
    logic [MS_W-1:0] step_len [STEP_SLOTS];
    // mirrored sequencer and idle timer
    bit              demo_on;
    logic [2:0]      step_no;
    logic [MS_W-1:0] step_ms;
    logic [MS_W-1:0] idle_ms;
    bit              idle_on;
    drive_t          pending_drives [$];
    int              mismatches;

    function new();
      idle_limit  = IDLE_TIMEOUT_RST;
      step_len[0] = STEP_FWD_RST;
      step_len[1] = STEP_TURN_RST;
      step_len[2] = STEP_FWD_RST;
      step_len[3] = STEP_TURN_RST;
      step_len[4] = STEP_FWD_RST;
      demo_on     = 1'b0;
      step_no     = '0;
      step_ms     = '0;
      idle_ms     = '0;
      idle_on     = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [MS_W-1:0] v);
      case (idx)
        REG_IDLE_TIMEOUT: idle_limit  = v;
        REG_STEP0:        step_len[0] = v;
        REG_STEP1:        step_len[1] = v;
        REG_STEP2:        step_len[2] = v;
        REG_STEP3:        step_len[3] = v;
        REG_STEP4:        step_len[4] = v;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return pending_drives.size();
    endfunction

    // Signed wheel speeds to magnitude and reverse flag, clipped at full speed
    function void queue_drive(int a, int b, cause_t c);
      drive_t d;
      int     ma;
      int     mb;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      if (ma > int'(SPEED_MAX)) ma = int'(SPEED_MAX);
      if (mb > int'(SPEED_MAX)) mb = int'(SPEED_MAX);
      d.left_reverse  = (a < 0);
      d.left_speed    = SPEED_W'(ma);
      d.right_reverse = (b < 0);
      d.right_speed   = SPEED_W'(mb);
      d.cause         = c;
      pending_drives.push_back(d);
    endfunction

    // Demo route: forward, left, forward, right, back
    function void queue_demo_step(int slot);
      case (slot)
        0:       queue_drive(100, 100, CAUSE_STEP);
        1:       queue_drive(-50, 150, CAUSE_STEP);
        2:       queue_drive(100, 100, CAUSE_STEP);
        3:       queue_drive(150, -50, CAUSE_STEP);
        default: queue_drive(-150, -150, CAUSE_STEP);
      endcase
    endfunction

    function void note_item(logic op, logic [7:0] ch);
      int nxt;
      int slot;
      if (op == OP_BYTE) begin
        idle_ms = '0;
        idle_on = 1'b1;
        case (ch)
          CH_STOP: begin
            demo_on = 1'b0;
            queue_drive(0, 0, CAUSE_KEY);
          end
          CH_W_UP, CH_W_LO, CH_I_UP, CH_I_LO: begin
            demo_on = 1'b0;
            queue_drive(100, 100, CAUSE_KEY);
          end
          CH_A_UP, CH_A_LO: begin
            demo_on = 1'b0;
            queue_drive(-50, 150, CAUSE_KEY);
          end
          CH_D_UP, CH_D_LO: begin
            demo_on = 1'b0;
            queue_drive(150, -50, CAUSE_KEY);
          end
          CH_S_UP, CH_S_LO: begin
            demo_on = 1'b0;
            queue_drive(-150, -150, CAUSE_KEY);
          end
          CH_K_UP, CH_K_LO: begin
            demo_on = 1'b0;
            queue_drive(150, 150, CAUSE_KEY);
          end
          CH_E_UP, CH_E_LO: begin
            step_no = '0;
            step_ms = '0;
            demo_on = 1'b1;
            queue_demo_step(0);
          end
          default: ;
        endcase
      end else if (demo_on) begin
        nxt  = int'(step_ms) + 1;
        slot = int'(step_no) % STEP_SLOTS;
        if (nxt >= int'(step_len[slot])) begin
          if (int'(step_no) + 1 >= DEMO_STEPS) begin
            demo_on = 1'b0;
            idle_on = 1'b0;
            queue_drive(0, 0, CAUSE_DONE);
          end else begin
            step_no = step_no + 3'd1;
            step_ms = '0;
            queue_demo_step(int'(step_no) % STEP_SLOTS);
          end
        end else begin
          step_ms = MS_W'(nxt);
        end
      end else if (idle_on) begin
        nxt = int'(idle_ms) + 1;
        if (nxt > int'(idle_limit)) begin
          idle_on = 1'b0;
          queue_drive(0, 0, CAUSE_IDLE);
        end else begin
          idle_ms = MS_W'(nxt);
        end
      end
    endfunction

    function void match(string field, logic [7:0] exp, logic [7:0] got);
      if (got !== exp) begin
        $error("%s: expected %0d, got %0d", field, exp, got);
        mismatches++;
      end
    endfunction

    function void check_drive(logic lrev, logic [SPEED_W-1:0] lspd,
                              logic rrev, logic [SPEED_W-1:0] rspd, logic [1:0] cause);
      drive_t e;
      if (pending_drives.size() == 0) begin
        $error("cause: expected no drive command, got %0d", cause);
        mismatches++;
        return;
      end
      e = pending_drives.pop_front();
      match("left_reverse",  8'(e.left_reverse),  8'(lrev));
      match("left_speed",    e.left_speed,        lspd);
      match("right_reverse", 8'(e.right_reverse), 8'(rrev));
      match("right_speed",   e.right_speed,       rspd);
      match("cause",         8'(e.cause),         8'(cause));
    endfunction
  endclass

endpackage

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motor command sequencer. Command bytes and
// millisecond ticks go in through a valid/ready channel with random gaps; the
// drive commands are taken with random back-pressure and checked against a
// scoreboard that tracks demo steps and the idle timer. The registers are
// reloaded between phases, covering zero, full scale and small step lengths.
// ----------------------------------------------------------------------------
module tb_top;
  import rcms_pkg::*;
  import rcms_tb_pkg::*;

  localparam int LIMIT = 400000;

  // keys that give a fixed drive command
  localparam logic [7:0] DRIVE_KEYS [13] = '{
    CH_STOP, CH_W_UP, CH_W_LO, CH_I_UP, CH_I_LO, CH_A_UP, CH_A_LO,
    CH_D_UP, CH_D_LO, CH_S_UP, CH_S_LO, CH_K_UP, CH_K_LO
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_op;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_left_reverse;
  logic [SPEED_W-1:0]   out_left_speed;
  logic                 out_right_reverse;
  logic [SPEED_W-1:0]   out_right_speed;
  logic [1:0]           out_cause;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MS_W-1:0]      cfg_data;

  drive_scoreboard sb;
  int items_sent = 0;
  int in_burst   = 0;
  int out_burst  = 0;
  int cycles     = 0;

  remote_command_motor_sequencer_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_left_reverse  (out_left_reverse),
    .out_left_speed    (out_left_speed),
    .out_right_reverse (out_right_reverse),
    .out_right_speed   (out_right_speed),
    .out_cause         (out_cause),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: a hung handshake or a missing drive command ends up here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Idle length for either side: mostly none or short, now and then long,
  // and occasionally a burst of back-to-back cycles with no idling at all
  function automatic int idle_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(15, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] any_key();
    return DRIVE_KEYS[$urandom_range(0, 12)];
  endfunction

  // Result side: drop out_ready for random stretches, set at the falling edge
  initial begin : drive_sink
    int stall;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        stall     = idle_gap(out_burst);
      end
    end
  end

  // Sample at the rising edge, before the block updates its outputs
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_drive(out_left_reverse, out_left_speed, out_right_reverse,
                     out_right_speed, out_cause);
    end
  end

  // Offer one item and hold it until taken. Called at a falling edge and
  // returns at one; valid stays high when the next item follows at once,
  // so whoever stops sending must lower it.
  task automatic send(logic op, logic [7:0] ch);
    int gap;
    in_op      = op;
    in_rx_byte = ch;
    in_valid   = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, ch);
    items_sent++;
    @(negedge clk);
    gap = idle_gap(in_burst);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Ticks carry a random byte so that the ignored payload bits still toggle
  task automatic tick();
    send(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Wait for every predicted drive command, then let any item that gives no
  // command drain through the two-stage pipe
  task automatic settle();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [MS_W-1:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Reload every register once pending drive commands are out; sequencer state is kept
  task automatic configure(logic [MS_W-1:0] timeout, logic [MS_W-1:0] s0,
                           logic [MS_W-1:0] s1, logic [MS_W-1:0] s2,
                           logic [MS_W-1:0] s3, logic [MS_W-1:0] s4);
    settle();
    cfg_write(REG_IDLE_TIMEOUT, timeout);
    cfg_write(REG_STEP0, s0);
    cfg_write(REG_STEP1, s1);
    cfg_write(REG_STEP2, s2);
    cfg_write(REG_STEP3, s3);
    cfg_write(REG_STEP4, s4);
  endtask

  // One random sequence: mostly a demo run or a key followed by idle ticks,
  // sized from the current registers so that steps and timeouts are reached
  task automatic random_burst();
    int r;
    int span;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      span = 5;
      for (int s = 0; s < STEP_SLOTS; s++) span += int'(sb.step_len[s]);
      if (span > 40) span = 40;
      send(OP_BYTE, $urandom_range(0, 1) ? CH_E_UP : CH_E_LO);
      repeat ($urandom_range(1, span)) begin
        // abort the demo now and then
        if ($urandom_range(0, 24) == 0) begin
          send(OP_BYTE, any_key());
        end else begin
          tick();
        end
      end
    end else if (r < 75) begin
      span = (int'(sb.idle_limit) > 10) ? 12 : int'(sb.idle_limit) + 2;
      if ($urandom_range(0, 2) == 0) begin
        send(OP_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        send(OP_BYTE, any_key());
      end
      repeat ($urandom_range(0, span)) tick();
    end else begin
      // noise: stray bytes and ticks
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1)) begin
          tick();
        end else begin
          send(OP_BYTE, 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  task automatic random_items(int budget);
    int stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) random_burst();
  endtask

  initial begin
    sb         = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = OP_BYTE;
    in_rx_byte = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_IDLE_TIMEOUT;
    cfg_data   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset register values: a tick before any byte (timer not
    // armed), every drive key, unknown bytes at both ends, a demo that is
    // restarted while running and then aborted by a key
    send(OP_TICK, 8'hFF);
    foreach (DRIVE_KEYS[k]) send(OP_BYTE, DRIVE_KEYS[k]);
    send(OP_BYTE, 8'h00);
    send(OP_BYTE, 8'hFF);
    send(OP_BYTE, CH_E_UP);
    tick();
    tick();
    send(OP_BYTE, CH_E_LO);
    tick();
    send(OP_BYTE, CH_S_UP);

    // Full scale: nothing times out; finish with the idle timer counting
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_items(40);
    send(OP_BYTE, CH_STOP);
    repeat (12) tick();

    // All zero: the timeout now sits below the count and fires on the next
    // tick; zero-length steps advance on every tick
    configure('0, '0, '0, '0, '0, '0);
    tick();
    random_items(40);

    // Full scale again, leaving a demo part way through its first step
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_items(30);
    send(OP_BYTE, CH_E_UP);
    repeat (10) tick();

    // Step shortened below the time already spent: advance on the next tick
    configure(16'd2, 16'd1, 16'd2, 16'd3, 16'd1, 16'd2);
    tick();
    random_items(45);

    // Small random lengths, so that demos complete and timeouts fire often
    repeat (3) begin
      configure(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
      random_items(40);
    end
    configure('0, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
              16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
              16'($urandom_range(0, 4)));
    random_items(45);

    // Drain, then allow for the pipeline before judging
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
